FILE: rtl/limit_order_book_matcher_top_assert.svh
// Assertion macros used by the order book top level.
// Bodies compile away when SYNTHESIS is defined.
`ifndef LIMIT_ORDER_BOOK_MATCHER_TOP_ASSERT_SVH
`define LIMIT_ORDER_BOOK_MATCHER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define LOBM_ASSERT_IMPL(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define LOBM_ASSERT_NEVER(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(expr)) else $error(msg);
`else
`define LOBM_ASSERT_IMPL(label, prop, msg)
`define LOBM_ASSERT_NEVER(label, expr, msg)
`endif
`endif

FILE: rtl/lobm_pkg.sv
// Shared types and constants for the limit order book matcher.
// No dependencies.
package lobm_pkg;
   localparam int ORDER_SLOTS = 64;
   localparam int SLOT_W      = $clog2(ORDER_SLOTS);
   localparam int CNT_W       = SLOT_W + 1;
   localparam int ID_W        = 16;
   localparam int SYM_W       = 4;
   localparam int PRICE_W     = 20;
   localparam int QTY_W       = 16;
   localparam int PSUM_W      = PRICE_W + 1;
   localparam logic [ID_W-1:0] ID_MAX   = '1;
   localparam logic [ID_W-1:0] ID_FIRST = ID_W'(1);
   localparam logic [5:0] DEAL_CAP = 6'd63;

   typedef enum logic [2:0] {
      KIND_ACCEPTED  = 3'd0,
      KIND_DEAL      = 3'd1,
      KIND_CANCELLED = 3'd2,
      KIND_NOT_FOUND = 3'd3,
      KIND_REJECTED  = 3'd4
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_SCAN, ST_DECIDE, ST_WB_BUY, ST_WB_SELL, ST_CSCAN, ST_CDONE
   } state_type;

   typedef struct packed {
      logic [ID_W-1:0]    id;
      logic [SYM_W-1:0]   sym;
      logic               side;
      logic [PRICE_W-1:0] price;
      logic [QTY_W-1:0]   qty;
   } entry_type;

   typedef struct packed {
      logic              wr_en;
      logic [SLOT_W-1:0] wr_addr;
      entry_type         wr_data;
      logic              clr_en;
      logic [SLOT_W-1:0] clr_addr;
      logic [SLOT_W-1:0] rd_addr;
   } store_ctl_type;

   typedef struct packed {
      logic               found;
      logic [SLOT_W-1:0]  slot;
      entry_type          ent;
   } best_type;

   typedef struct packed {
      kind_type           kind;
      logic [ID_W-1:0]    report_id;
      logic [ID_W-1:0]    buy_id;
      logic [ID_W-1:0]    sell_id;
      logic [SYM_W-1:0]   order_symbol;
      logic               order_side;
      logic [PRICE_W-1:0] order_price;
      logic [QTY_W-1:0]   quantity;
      logic [PSUM_W-1:0]  deal_price_sum;
      logic               last;
   } rsp_type;
endpackage

FILE: rtl/limit_order_book_matcher_top.sv
// Limit order book matcher, top level: request decode, scan/match sequencer,
// result register. Depends on lobm_pkg, lobm_store and the assert header.
//
// Channel  Direction  Handshake              Payload
// req      in         start & !busy          req_func .. req_cancel_id
// rsp      out        rsp_valid, one cycle   rsp_kind .. rsp_last
//
// A new order with nonzero quantity is first inserted, then each match pass
// reads one store slot per cycle over 64 slots and then decides, plus a buy
// and a sell writeback per deal. Zero quantity or a full store: no scan.
// A cancel is one full scan of the store plus the report.
// Reset clears all valid bits at once; the store needs no clearing pass.
// Results leave on a one-cycle strobe; the receiver cannot stall.
module limit_order_book_matcher_top (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic                             req_func,
   input  logic [lobm_pkg::SYM_W-1:0]       req_symbol,
   input  logic                             req_side,
   input  logic [lobm_pkg::PRICE_W-1:0]     req_limit_price,
   input  logic [lobm_pkg::QTY_W-1:0]       req_order_qty,
   input  logic [lobm_pkg::ID_W-1:0]        req_cancel_id,
   output logic                             rsp_valid,
   output logic [2:0]                       rsp_kind,
   output logic [lobm_pkg::ID_W-1:0]        rsp_report_id,
   output logic [lobm_pkg::ID_W-1:0]        rsp_buy_id,
   output logic [lobm_pkg::ID_W-1:0]        rsp_sell_id,
   output logic [lobm_pkg::SYM_W-1:0]       rsp_order_symbol,
   output logic                             rsp_order_side,
   output logic [lobm_pkg::PRICE_W-1:0]     rsp_order_price,
   output logic [lobm_pkg::QTY_W-1:0]       rsp_quantity,
   output logic [lobm_pkg::PSUM_W-1:0]      rsp_deal_price_sum,
   output logic                             rsp_last
);
   import lobm_pkg::*;
   `include "limit_order_book_matcher_top_assert.svh"

   state_type           state_ff, state_in;
   logic [SYM_W-1:0]    sym_ff, sym_in;
   logic [ID_W-1:0]     cid_ff, cid_in;
   logic [ID_W-1:0]     oid_ff, oid_in;
   logic [ID_W-1:0]     next_id_ff, next_id_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [5:0]          deals_ff, deals_in;
   logic [QTY_W-1:0]    dq_ff, dq_in;
   best_type            bid_ff, bid_in, ask_ff, ask_in;
   rsp_type             pend_ff, pend_in, out_ff, out_in;
   logic                out_vld_ff, out_vld_in;

   store_ctl_type       ctl;
   entry_type           rd_data;
   logic                rd_valid;
   logic                free_found;
   logic [SLOT_W-1:0]   free_slot;
   logic [SLOT_W-1:0]   rd_slot;
   logic [QTY_W-1:0]    dq;
   entry_type           new_ent;
   rsp_type             blank;

   lobm_store u_store (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .rd_data    (rd_data),
      .rd_valid   (rd_valid),
      .free_found (free_found),
      .free_slot  (free_slot)
   );

   assign rd_slot = SLOT_W'(cnt_ff - CNT_W'(1));
   assign dq      = (bid_ff.ent.qty < ask_ff.ent.qty) ? bid_ff.ent.qty : ask_ff.ent.qty;

   always_comb begin
      blank      = '0;
      blank.kind = KIND_ACCEPTED;
      // Symbol is 4 bits and the book has 16 symbols: no reduction needed.
      new_ent.id    = next_id_ff;
      new_ent.sym   = req_symbol;
      new_ent.side  = req_side;
      new_ent.price = req_limit_price;
      new_ent.qty   = req_order_qty;

      state_in   = state_ff;
      sym_in     = sym_ff;
      cid_in     = cid_ff;
      oid_in     = oid_ff;
      next_id_in = next_id_ff;
      cnt_in     = cnt_ff;
      deals_in   = deals_ff;
      dq_in      = dq_ff;
      bid_in     = bid_ff;
      ask_in     = ask_ff;
      pend_in    = pend_ff;
      out_in     = out_ff;
      out_vld_in = 1'b0;
      ctl        = '0;
      ctl.rd_addr = cnt_ff[SLOT_W-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cnt_in     = '0;
               bid_in     = '0;
               ask_in     = '0;
               cid_in     = req_cancel_id;
               sym_in     = req_symbol;
               if (req_func) begin
                  state_in = ST_CSCAN;
               end else begin
                  oid_in     = next_id_ff;
                  next_id_in = (next_id_ff == ID_MAX) ? ID_FIRST : next_id_ff + ID_W'(1);
                  out_in           = blank;
                  out_in.report_id = next_id_ff;
                  if (req_order_qty == '0) begin
                     out_in.last = 1'b1;
                     out_vld_in  = 1'b1;
                  end else if (!free_found) begin
                     out_in.kind = KIND_REJECTED;
                     out_in.last = 1'b1;
                     out_vld_in  = 1'b1;
                  end else begin
                     // Hold the ack until we know whether a deal follows.
                     pend_in     = out_in;
                     ctl.wr_en   = 1'b1;
                     ctl.wr_addr = free_slot;
                     ctl.wr_data = new_ent;
                     deals_in    = '0;
                     state_in    = ST_SCAN;
                  end
               end
            end
         end
         ST_SCAN: begin
            if (cnt_ff != '0 && rd_valid && rd_data.sym == sym_ff) begin
               if (!rd_data.side) begin
                  if (!bid_ff.found || ((rd_data.price == bid_ff.ent.price) ?
                        (rd_data.id < bid_ff.ent.id) : (rd_data.price > bid_ff.ent.price))) begin
                     bid_in.found = 1'b1;
                     bid_in.slot  = rd_slot;
                     bid_in.ent   = rd_data;
                  end
               end else begin
                  if (!ask_ff.found || ((rd_data.price == ask_ff.ent.price) ?
                        (rd_data.id < ask_ff.ent.id) : (rd_data.price < ask_ff.ent.price))) begin
                     ask_in.found = 1'b1;
                     ask_in.slot  = rd_slot;
                     ask_in.ent   = rd_data;
                  end
               end
            end
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(ORDER_SLOTS)) state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            out_in     = pend_ff;
            out_vld_in = 1'b1;
            if (bid_ff.found && ask_ff.found && bid_ff.ent.price >= ask_ff.ent.price &&
                  deals_ff != DEAL_CAP) begin
               pend_in                = blank;
               pend_in.kind           = KIND_DEAL;
               pend_in.report_id      = oid_ff;
               pend_in.buy_id         = bid_ff.ent.id;
               pend_in.sell_id        = ask_ff.ent.id;
               pend_in.quantity       = dq;
               pend_in.deal_price_sum = PSUM_W'(bid_ff.ent.price) + PSUM_W'(ask_ff.ent.price);
               dq_in    = dq;
               deals_in = deals_ff + 6'd1;
               state_in = ST_WB_BUY;
            end else begin
               out_in.last = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         ST_WB_BUY: begin
            ctl.wr_addr     = bid_ff.slot;
            ctl.wr_data     = bid_ff.ent;
            ctl.wr_data.qty = bid_ff.ent.qty - dq_ff;
            ctl.clr_addr    = bid_ff.slot;
            if (bid_ff.ent.qty == dq_ff) ctl.clr_en = 1'b1;
            else                         ctl.wr_en  = 1'b1;
            state_in = ST_WB_SELL;
         end
         ST_WB_SELL: begin
            ctl.wr_addr     = ask_ff.slot;
            ctl.wr_data     = ask_ff.ent;
            ctl.wr_data.qty = ask_ff.ent.qty - dq_ff;
            ctl.clr_addr    = ask_ff.slot;
            if (ask_ff.ent.qty == dq_ff) ctl.clr_en = 1'b1;
            else                         ctl.wr_en  = 1'b1;
            cnt_in   = '0;
            bid_in   = '0;
            ask_in   = '0;
            state_in = ST_SCAN;
         end
         ST_CSCAN: begin
            // First valid slot with a matching id wins.
            if (cnt_ff != '0 && rd_valid && rd_data.id == cid_ff && !bid_ff.found) begin
               bid_in.found = 1'b1;
               bid_in.slot  = rd_slot;
               bid_in.ent   = rd_data;
            end
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(ORDER_SLOTS)) state_in = ST_CDONE;
         end
         ST_CDONE: begin
            out_in      = blank;
            out_in.last = 1'b1;
            out_vld_in  = 1'b1;
            if (bid_ff.found) begin
               out_in.kind         = KIND_CANCELLED;
               out_in.report_id    = bid_ff.ent.id;
               out_in.order_symbol = bid_ff.ent.sym;
               out_in.order_side   = bid_ff.ent.side;
               out_in.order_price  = bid_ff.ent.price;
               out_in.quantity     = bid_ff.ent.qty;
               ctl.clr_en          = 1'b1;
               ctl.clr_addr        = bid_ff.slot;
            end else begin
               out_in.kind      = KIND_NOT_FOUND;
               out_in.report_id = cid_ff;
            end
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         next_id_ff <= ID_FIRST;
         out_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         next_id_ff <= next_id_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      sym_ff   <= sym_in;
      cid_ff   <= cid_in;
      oid_ff   <= oid_in;
      cnt_ff   <= cnt_in;
      deals_ff <= deals_in;
      dq_ff    <= dq_in;
      bid_ff   <= bid_in;
      ask_ff   <= ask_in;
      pend_ff  <= pend_in;
      out_ff   <= out_in;
   end

   assign busy               = (state_ff != ST_IDLE);
   assign rsp_valid          = out_vld_ff;
   assign rsp_kind           = out_ff.kind;
   assign rsp_report_id      = out_ff.report_id;
   assign rsp_buy_id         = out_ff.buy_id;
   assign rsp_sell_id        = out_ff.sell_id;
   assign rsp_order_symbol   = out_ff.order_symbol;
   assign rsp_order_side     = out_ff.order_side;
   assign rsp_order_price    = out_ff.order_price;
   assign rsp_quantity       = out_ff.quantity;
   assign rsp_deal_price_sum = out_ff.deal_price_sum;
   assign rsp_last           = out_ff.last;

   `LOBM_ASSERT_IMPL(a_more_follows, rsp_valid && !rsp_last |-> busy, "non-final result while idle")
   `LOBM_ASSERT_IMPL(a_accept_progress, start && !busy |=> busy || (rsp_valid && rsp_last), "accepted request dropped")
   `LOBM_ASSERT_NEVER(a_deal_qty, rsp_valid && rsp_kind == KIND_DEAL && rsp_quantity == '0, "empty deal")
endmodule

FILE: rtl/lobm_store.sv
// Order store: entry memory with registered read, per-slot valid flops,
// and the lowest-free-slot finder. Depends on lobm_pkg.
module lobm_store (
   input  logic                         clock,
   input  logic                         reset,
   input  lobm_pkg::store_ctl_type      ctl,
   output lobm_pkg::entry_type          rd_data,
   output logic                         rd_valid,
   output logic                         free_found,
   output logic [lobm_pkg::SLOT_W-1:0]  free_slot
);
   import lobm_pkg::*;

   entry_type               mem [ORDER_SLOTS];
   logic [ORDER_SLOTS-1:0]  valid_ff;
   entry_type               rd_data_ff;
   logic                    rd_valid_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[ctl.wr_addr] <= ctl.wr_data;
      end
      rd_data_ff  <= mem[ctl.rd_addr];
      rd_valid_ff <= valid_ff[ctl.rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (ctl.wr_en) valid_ff[ctl.wr_addr] <= 1'b1;
         if (ctl.clr_en) valid_ff[ctl.clr_addr] <= 1'b0;
      end
   end

   // Lowest invalid slot.
   always_comb begin
      free_found = 1'b0;
      free_slot  = '0;
      for (int i = ORDER_SLOTS - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_found = 1'b1;
            free_slot  = SLOT_W'(i);
         end
      end
   end

   assign rd_data  = rd_data_ff;
   assign rd_valid = rd_valid_ff;
endmodule
